// ===== rtl/fcl_pkg.sv =====
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types and constants of the fault change logger: transaction structs,
// operation codes, chain commands and storage sizes.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int FLAG_BYTES = 16;
  localparam int ACTIVE_CAP = 128;
  localparam int ACT_AW     = $clog2(ACTIVE_CAP);
  localparam int LOG_DEPTH  = 32;
  localparam int LOG_AW     = $clog2(LOG_DEPTH);
  localparam int CODE_W     = 7;
  localparam int CMP_W      = 16;

  localparam logic [1:0] OP_UPDATE      = 2'd0;
  localparam logic [1:0] OP_READ_ACTIVE = 2'd1;
  localparam logic [1:0] OP_READ_LOG    = 2'd2;

  typedef enum logic [1:0] {
    CHAIN_APPEND,
    CHAIN_REMOVE,
    CHAIN_READ
  } chain_op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] byte_sel;
    logic [7:0] byte_value;
    logic [7:0] query_index;
  } item_t;

  typedef struct packed {
    logic [6:0] fault_code;
    logic       occurred;
    logic       valid_res;
    logic       last;
    logic [4:0] log_position;
    logic [7:0] active_count;
  } result_t;

  typedef struct packed {
    logic                start;
    chain_op_t           op;
    logic [CODE_W-1:0]   key;
    logic [ACT_AW-1:0]   target;
  } chain_cmd_t;

  typedef struct packed {
    logic                done;
    logic [ACT_AW:0]     total;
    logic [CODE_W-1:0]   rdata;
  } chain_stat_t;

endpackage

// ===== rtl/fcl_cell.sv =====
// ----------------------------------------------------------------------------
// fcl_cell
// One slot of the active fault list: holds a fault code and loads the code
// of its neighbor while the chain advances.
// ----------------------------------------------------------------------------
module fcl_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [fcl_pkg::CODE_W-1:0] d,
  output logic [fcl_pkg::CODE_W-1:0] q
);

  logic [fcl_pkg::CODE_W-1:0] code;

  always_ff @(posedge clk) begin
    if (shift) begin
      code <= d;
    end
  end

  assign q = code;

endmodule

// ===== rtl/fcl_chain.sv =====
// ----------------------------------------------------------------------------
// fcl_chain
// Active fault list as a ring of cells. A pass rotates the ring once around;
// the tail feed inserts an appended code, skips a removed one, and the head
// is sampled for a positional read.
// ----------------------------------------------------------------------------
module fcl_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  fcl_pkg::chain_cmd_t  cmd,
  output fcl_pkg::chain_stat_t stat
);

  localparam int CAP = fcl_pkg::ACTIVE_CAP;
  localparam int AW  = fcl_pkg::ACT_AW;
  localparam int CW  = fcl_pkg::CODE_W;

  logic [CW-1:0] cell_q [CAP];
  logic [CW-1:0] cell_d [CAP];

  logic                running;
  logic                done;
  logic [AW-1:0]       step;
  logic [AW:0]         total;
  logic                dropped;
  fcl_pkg::chain_op_t  op;
  logic [CW-1:0]       key;
  logic [AW-1:0]       target;
  logic [CW-1:0]       rdata;

  logic [CW-1:0] head;
  logic [CW-1:0] second;
  logic [CW-1:0] feed;
  logic          in_list;
  logic          hit;

  assign head    = cell_q[0];
  assign second  = cell_q[1];
  assign in_list = {1'b0, step} < total;
  assign hit     = (op == fcl_pkg::CHAIN_REMOVE) && !dropped && in_list && (head == key);

  always_comb begin
    case (op)
      fcl_pkg::CHAIN_APPEND: feed = ({1'b0, step} == total) ? key : head;
      fcl_pkg::CHAIN_REMOVE: feed = (dropped || hit) ? second : head;
      default:               feed = head;
    endcase
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    if (i == CAP - 1) begin : g_tail
      assign cell_d[i] = feed;
    end else begin : g_body
      assign cell_d[i] = cell_q[i+1];
    end
    fcl_cell u_cell (
      .clk   (clk),
      .shift (running),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      total   <= '0;
      dropped <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (!running && cmd.start) begin
        running <= 1'b1;
        step    <= '0;
        dropped <= 1'b0;
      end else if (running) begin
        step <= step + 1'b1;
        if (hit) begin
          dropped <= 1'b1;
        end
        if (step == AW'(CAP - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
          case (op)
            fcl_pkg::CHAIN_APPEND: begin
              if (total < (AW+1)'(CAP)) begin
                total <= total + 1'b1;
              end
            end
            fcl_pkg::CHAIN_REMOVE: begin
              if (dropped || hit) begin
                total <= total - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!running && cmd.start) begin
      op     <= cmd.op;
      key    <= cmd.key;
      target <= cmd.target;
    end
    if (running && (op == fcl_pkg::CHAIN_READ) && (step == target)) begin
      rdata <= head;
    end
  end

  assign stat.done  = done;
  assign stat.total = total;
  assign stat.rdata = rdata;

endmodule

// ===== rtl/fault_change_logger_top.sv =====
// ----------------------------------------------------------------------------
// fault_change_logger_top
// Watches 128 fault flags updated a byte at a time, reports each changed flag
// as an event, keeps an ordered active fault list and a wrapping event log,
// and answers positional reads of either.
//
// Channel   Signals                    Transfer
// input     start, busy, item          start high while busy low
// result    result_valid, result       one cycle per result, no stall
//
// An update with no changed bit passes the scan state and returns to idle.
// Each changed bit then passes a scan state, one full rotation of the 128-cell
// active list and the done strobe (a set flag with the list full skips both).
// An active read waits on the same rotation, a log read on the log RAM port,
// a read past the end on neither; busy drops as the last result is shown.
// Reset (rst, synchronous) clears the flag bytes, list count, log index and
// wrap flag; list cells and log contents are not cleared.
// ----------------------------------------------------------------------------
module fault_change_logger_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fcl_pkg::item_t   item,
  output logic             busy,
  output logic             result_valid,
  output fcl_pkg::result_t result
);

  localparam int AW  = fcl_pkg::LOG_AW;
  localparam int DEP = fcl_pkg::LOG_DEPTH;
  localparam int CW  = fcl_pkg::CODE_W;
  localparam int XW  = fcl_pkg::CMP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVENT,
    S_ACTIVE,
    S_LOGRD
  } state_t;

  state_t state;

  logic [7:0]   prev_flags [fcl_pkg::FLAG_BYTES];
  logic [7:0]   diff;
  logic [7:0]   value;
  logic [3:0]   byte_idx;
  logic [CW-1:0] ev_code_r;
  logic         ev_occ_r;
  logic [AW-1:0] wr_idx;
  logic         wrapped;

  logic [7:0]   log_mem [DEP];
  logic [7:0]   log_rd;

  fcl_pkg::chain_cmd_t  cmd;
  fcl_pkg::chain_stat_t stat;

  logic          accept;
  logic [2:0]    ev_bit;
  logic [CW-1:0] ev_code;
  logic          ev_occ;
  logic [7:0]    diff_left;
  logic          ev_pass;
  logic          log_we;
  logic [AW-1:0] wr_next;
  logic          wrap_now;
  logic [AW:0]   held;
  logic          log_hit;
  logic [AW:0]   log_sum;
  logic [AW-1:0] log_addr;
  logic          log_re;
  logic          act_hit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    ev_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (diff[i]) begin
        ev_bit = 3'(i);
      end
    end
  end

  assign ev_code   = {byte_idx, ev_bit};
  assign ev_occ    = value[ev_bit];
  assign diff_left = diff & ~(8'd1 << ev_bit);
  assign ev_pass   = !ev_occ || (stat.total < (fcl_pkg::ACT_AW+1)'(fcl_pkg::ACTIVE_CAP));
  assign log_we    = (state == S_SCAN) && (diff != 8'd0);
  assign wrap_now  = (wr_idx == AW'(DEP - 1));
  assign wr_next   = wrap_now ? '0 : wr_idx + 1'b1;

  assign held     = wrapped ? (AW+1)'(DEP) : {1'b0, wr_idx};
  assign log_hit  = XW'(item.query_index) < XW'(held);
  assign log_sum  = {1'b0, wr_idx} + (AW+1)'(DEP - 1) - {1'b0, AW'(item.query_index)};
  assign log_addr = (log_sum >= (AW+1)'(DEP)) ? AW'(log_sum - (AW+1)'(DEP)) : AW'(log_sum);
  assign log_re   = accept && (item.operation == fcl_pkg::OP_READ_LOG) && log_hit;
  assign act_hit  = XW'(item.query_index) < XW'(stat.total);

  always_comb begin
    cmd.start  = 1'b0;
    cmd.op     = fcl_pkg::CHAIN_READ;
    cmd.key    = ev_code;
    cmd.target = fcl_pkg::ACT_AW'(stat.total - 8'd1 - item.query_index);
    if (log_we) begin
      cmd.start = ev_pass;
      cmd.op    = ev_occ ? fcl_pkg::CHAIN_APPEND : fcl_pkg::CHAIN_REMOVE;
    end else if (accept && (item.operation == fcl_pkg::OP_READ_ACTIVE) && act_hit) begin
      cmd.start = 1'b1;
    end
  end

  fcl_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[wr_idx] <= {ev_occ, ev_code};
    end
    if (log_re) begin
      log_rd <= log_mem[log_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      wr_idx       <= '0;
      wrapped      <= 1'b0;
      diff         <= 8'd0;
      for (int i = 0; i < fcl_pkg::FLAG_BYTES; i++) begin
        prev_flags[i] <= 8'd0;
      end
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.operation)
              fcl_pkg::OP_UPDATE: begin
                if (XW'(item.byte_sel) < XW'(fcl_pkg::FLAG_BYTES)) begin
                  prev_flags[item.byte_sel] <= item.byte_value;
                  diff     <= prev_flags[item.byte_sel] ^ item.byte_value;
                  value    <= item.byte_value;
                  byte_idx <= item.byte_sel;
                  state    <= S_SCAN;
                end
              end
              fcl_pkg::OP_READ_ACTIVE: begin
                if (act_hit) begin
                  state <= S_ACTIVE;
                end else begin
                  result_valid        <= 1'b1;
                  result.fault_code   <= '0;
                  result.occurred     <= 1'b0;
                  result.valid_res    <= 1'b0;
                  result.last         <= 1'b1;
                  result.log_position <= 5'(wr_idx);
                  result.active_count <= 8'(stat.total);
                end
              end
              fcl_pkg::OP_READ_LOG: begin
                if (log_hit) begin
                  state <= S_LOGRD;
                end else begin
                  result_valid        <= 1'b1;
                  result.fault_code   <= '0;
                  result.occurred     <= 1'b0;
                  result.valid_res    <= 1'b0;
                  result.last         <= 1'b1;
                  result.log_position <= 5'(wr_idx);
                  result.active_count <= 8'(stat.total);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (diff == 8'd0) begin
            state <= S_IDLE;
          end else begin
            wr_idx    <= wr_next;
            if (wrap_now) begin
              wrapped <= 1'b1;
            end
            diff      <= diff_left;
            ev_code_r <= ev_code;
            ev_occ_r  <= ev_occ;
            if (ev_pass) begin
              state <= S_EVENT;
            end else begin
              result_valid        <= 1'b1;
              result.fault_code   <= ev_code;
              result.occurred     <= ev_occ;
              result.valid_res    <= 1'b1;
              result.last         <= (diff_left == 8'd0);
              result.log_position <= 5'(wr_next);
              result.active_count <= 8'(stat.total);
              state               <= (diff_left == 8'd0) ? S_IDLE : S_SCAN;
            end
          end
        end
        S_EVENT: begin
          if (stat.done) begin
            result_valid        <= 1'b1;
            result.fault_code   <= ev_code_r;
            result.occurred     <= ev_occ_r;
            result.valid_res    <= 1'b1;
            result.last         <= (diff == 8'd0);
            result.log_position <= 5'(wr_idx);
            result.active_count <= 8'(stat.total);
            state               <= (diff == 8'd0) ? S_IDLE : S_SCAN;
          end
        end
        S_ACTIVE: begin
          if (stat.done) begin
            result_valid        <= 1'b1;
            result.fault_code   <= stat.rdata;
            result.occurred     <= 1'b1;
            result.valid_res    <= 1'b1;
            result.last         <= 1'b1;
            result.log_position <= 5'(wr_idx);
            result.active_count <= 8'(stat.total);
            state               <= S_IDLE;
          end
        end
        S_LOGRD: begin
          result_valid        <= 1'b1;
          result.fault_code   <= log_rd[CW-1:0];
          result.occurred     <= log_rd[7];
          result.valid_res    <= 1'b1;
          result.last         <= 1'b1;
          result.log_position <= 5'(wr_idx);
          result.active_count <= 8'(stat.total);
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_EVENT || state == S_ACTIVE))
    else $error("chain pass ended outside a wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.total <= (fcl_pkg::ACT_AW+1)'(fcl_pkg::ACTIVE_CAP))
    else $error("active count above list capacity");

  a_wrap_index: assert property (@(posedge clk) disable iff (rst)
    $rose(wrapped) |-> (wr_idx == '0))
    else $error("log wrap flag set away from index zero");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !$past(cmd.start) && !stat.done)
    else $error("chain pass issued while a pass is pending");

endmodule
